/* hw/rtl/smnt_pkg.sv */
// smnt_pkg: shared types, constants and calendar helpers for the schedule mask search.
// Used by smnt_ctrl, smnt_dp and schedule_mask_next_time. No dependencies.
package smnt_pkg;

    localparam int TIME_W  = 34;
    localparam int START_W = 35;
    localparam int DAY_W   = 18;
    localparam int TOD_W   = 17;
    localparam int CFG_W   = 60;

    localparam int SEARCH_LIMIT_YEARS = 5;
    localparam logic [START_W-1:0] LIMIT_SECS = START_W'(SEARCH_LIMIT_YEARS * 31556952);
    localparam logic [START_W-1:0] TIME_MAX   = START_W'(35'h3FFFFFFFF);
    localparam logic [TOD_W-1:0]   SECS_PER_DAY = 17'd86400;

    localparam logic [8:0] EPOCH_Y400 = 9'd370;
    localparam logic [2:0] EPOCH_WD   = 3'd4;

    localparam logic [2:0] REG_SECOND = 3'd0;
    localparam logic [2:0] REG_MINUTE = 3'd1;
    localparam logic [2:0] REG_HOUR   = 3'd2;
    localparam logic [2:0] REG_MONTH  = 3'd3;
    localparam logic [2:0] REG_DOM    = 3'd4;
    localparam logic [2:0] REG_WDAY   = 3'd5;
    localparam logic [2:0] REG_LWDAY  = 3'd6;
    localparam logic [2:0] REG_NTH    = 3'd7;

    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_PREV = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic tod_calc;
        logic year_step;
        logic month_step;
        logic day_set;
        logic scan;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic year_more;
        logic month_more;
        logic scan_end;
    } dp_stat_t;

    function automatic logic is_leap(input logic [8:0] y400);
        return (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200)
            && (y400 != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] r;
        case (mon)
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] wd_add(input logic [2:0] w, input logic [2:0] a);
        logic [3:0] s;
        s = {1'b0, w} + {1'b0, a};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

    // lowest set bit at or above k: {hit, index}
    function automatic logic [6:0] first_ge(input logic [63:0] mask, input logic [5:0] k);
        logic [6:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            if (mask[i] && (6'(i) >= k)) begin
                r = {1'b1, 6'(i)};
            end
        end
        return r;
    endfunction

    // highest set bit at or below k: {hit, index}
    function automatic logic [6:0] last_le(input logic [63:0] mask, input logic [5:0] k);
        logic [6:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            if (mask[i] && (6'(i) <= k)) begin
                r = {1'b1, 6'(i)};
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/smnt_ctrl.sv */
// smnt_ctrl: sequencer for the schedule mask search.
// Drives smnt_dp through ctrl_cmd_t and reads dp_stat_t; depends on smnt_pkg.
module smnt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  smnt_pkg::dp_stat_t    stat,
    output smnt_pkg::ctrl_cmd_t   cmd
);
    import smnt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_TODS  = 3'd2;
    localparam logic [2:0] S_YEAR  = 3'd3;
    localparam logic [2:0] S_MONTH = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_TODS;
                end
            end
            S_TODS:
            begin
                cmd.tod_calc = 1'b1;
                state_next   = S_YEAR;
            end
            S_YEAR:
            begin
                if (stat.year_more)
                begin
                    cmd.year_step = 1'b1;
                end
                else
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (stat.month_more)
                begin
                    cmd.month_step = 1'b1;
                end
                else
                begin
                    cmd.day_set = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_FIN);

endmodule

/* hw/rtl/smnt_dp.sv */
// smnt_dp: mask registers, epoch-second split, calendar walk and day scan.
// Commanded by smnt_ctrl; depends on smnt_pkg.
module smnt_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [2:0]                    cfg_index,
    input  logic [smnt_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          op,
    input  logic [smnt_pkg::TIME_W-1:0]   from_time,
    input  smnt_pkg::ctrl_cmd_t           cmd,
    output smnt_pkg::dp_stat_t            stat,
    output logic                          found,
    output logic [smnt_pkg::TIME_W-1:0]   match_time
);
    import smnt_pkg::*;

    // reciprocals: 2^37/675, 2^21/225, 2^14/15, each rounded up
    localparam logic [27:0] DAY_RECIP  = 28'd203613265;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam logic [5:0]  DIV_LAST   = 6'd5;

    logic [59:0] sec_mask_reg;
    logic [59:0] min_mask_reg;
    logic [23:0] hour_mask_reg;
    logic [12:0] month_mask_reg;
    logic [31:0] dom_mask_reg;
    logic [6:0]  wday_mask_reg;
    logic [6:0]  lwday_mask_reg;
    logic [34:0] nth_mask_reg;

    logic              op_reg;
    logic [TIME_W-1:0] from_reg;
    logic [TIME_W-1:0] n_reg;
    logic [5:0]        cnt_reg;
    logic [TOD_W-1:0]  tod_reg;
    logic [11:0]       hrem_reg;
    logic [5:0]        sec_reg;
    logic [5:0]        min_reg;
    logic [4:0]        hr_reg;
    logic              hit_first_reg;
    logic [TOD_W-1:0]  tod_first_reg;
    logic              hit_any_reg;
    logic [TOD_W-1:0]  tod_any_reg;
    logic [START_W-1:0] start_reg;
    logic [DAY_W-1:0]  days_reg;
    logic [8:0]        y400_reg;
    logic [3:0]        mon_reg;
    logic [4:0]        day_reg;
    logic [2:0]        wd_reg;
    logic              first_reg;
    logic              found_reg;
    logic [TIME_W-1:0] time_reg;

    // split from_time into day, hour, minute, second
    logic [54:0]      day_prod;
    logic [TOD_W-1:0] tod_next;
    logic [26:0]      hour_prod;
    logic [11:0]      hrem_next;
    logic [20:0]      min_prod;
    logic [5:0]       sec_next;

    assign day_prod  = 55'(from_reg[TIME_W-1:7]) * 55'(DAY_RECIP);
    assign tod_next  = from_reg[TOD_W-1:0] - n_reg[TOD_W-1:0] * SECS_PER_DAY;
    assign hour_prod = 27'(tod_reg[TOD_W-1:4]) * 27'(HOUR_RECIP);
    assign hrem_next = tod_reg[11:0] - 12'(hr_reg) * 12'd3600;
    assign min_prod  = 21'(hrem_reg[11:2]) * 21'(MIN_RECIP);
    assign sec_next  = hrem_reg[5:0] - min_reg * 6'd60;

    // time-of-day candidates
    logic [63:0] sm, mm, hm;
    logic [6:0]  s_lo, m_lo, h_lo, s_hi, m_hi, h_hi;
    logic [6:0]  n1, n2, n3, p1, p2, p3;
    logic        h_ok, m_ok;
    logic        fh_hit, ah_hit;
    logic [5:0]  fh, fm, fs, ah, am, as_;
    logic [TOD_W-1:0] ftod, atod;

    assign sm = {4'd0, sec_mask_reg};
    assign mm = {4'd0, min_mask_reg};
    assign hm = {40'd0, hour_mask_reg};

    always_comb
    begin
        s_lo = first_ge(sm, 6'd0);
        m_lo = first_ge(mm, 6'd0);
        h_lo = first_ge(hm, 6'd0);
        s_hi = last_le(sm, 6'd59);
        m_hi = last_le(mm, 6'd59);
        h_hi = last_le(hm, 6'd23);
        n1 = first_ge(sm, sec_reg + 6'd1);
        n2 = first_ge(mm, min_reg + 6'd1);
        n3 = first_ge(hm, {1'b0, hr_reg} + 6'd1);
        p1 = (sec_reg != 6'd0) ? last_le(sm, sec_reg - 6'd1) : 7'd0;
        p2 = (min_reg != 6'd0) ? last_le(mm, min_reg - 6'd1) : 7'd0;
        p3 = (hr_reg != 5'd0) ? last_le(hm, {1'b0, hr_reg} - 6'd1) : 7'd0;
        h_ok = hour_mask_reg[hr_reg];
        m_ok = min_mask_reg[min_reg];
        fh = {1'b0, hr_reg};
        fm = min_reg;
        fs = 6'd0;
        fh_hit = 1'b0;
        if (op_reg == OP_NEXT)
        begin
            ah_hit = h_lo[6] && m_lo[6] && s_lo[6];
            ah = h_lo[5:0];
            am = m_lo[5:0];
            as_ = s_lo[5:0];
            if (h_ok && m_ok && n1[6])
            begin
                fh_hit = 1'b1;
                fs = n1[5:0];
            end
            else if (h_ok && n2[6] && s_lo[6])
            begin
                fh_hit = 1'b1;
                fm = n2[5:0];
                fs = s_lo[5:0];
            end
            else if (n3[6] && m_lo[6] && s_lo[6])
            begin
                fh_hit = 1'b1;
                fh = n3[5:0];
                fm = m_lo[5:0];
                fs = s_lo[5:0];
            end
        end
        else
        begin
            ah_hit = h_hi[6] && m_hi[6] && s_hi[6];
            ah = h_hi[5:0];
            am = m_hi[5:0];
            as_ = s_hi[5:0];
            if (h_ok && m_ok && p1[6])
            begin
                fh_hit = 1'b1;
                fs = p1[5:0];
            end
            else if (h_ok && p2[6] && s_hi[6])
            begin
                fh_hit = 1'b1;
                fm = p2[5:0];
                fs = s_hi[5:0];
            end
            else if (p3[6] && m_hi[6] && s_hi[6])
            begin
                fh_hit = 1'b1;
                fh = p3[5:0];
                fm = m_hi[5:0];
                fs = s_hi[5:0];
            end
        end
        ftod = TOD_W'(fh) * 17'd3600 + TOD_W'(fm) * 17'd60 + TOD_W'(fs);
        atod = TOD_W'(ah) * 17'd3600 + TOD_W'(am) * 17'd60 + TOD_W'(as_);
    end

    // calendar
    logic       leap_y;
    logic [8:0] ylen;
    logic [4:0] mlen;
    logic [8:0] y400_inc, y400_dec;
    logic [3:0] prev_mon;
    logic [8:0] prev_y400;
    logic [4:0] prev_mlen;
    logic [2:0] day_wd_off;

    assign leap_y    = is_leap(y400_reg);
    assign ylen      = leap_y ? 9'd366 : 9'd365;
    assign mlen      = month_len(mon_reg, leap_y);
    assign y400_inc  = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
    assign y400_dec  = (y400_reg == 9'd0) ? 9'd399 : y400_reg - 9'd1;
    assign prev_mon  = (mon_reg == 4'd1) ? 4'd12 : mon_reg - 4'd1;
    assign prev_y400 = (mon_reg == 4'd1) ? y400_dec : y400_reg;
    assign prev_mlen = month_len(prev_mon, is_leap(prev_y400));

    // weekday offset of the day from the first of its month
    always_comb
    begin
        if (days_reg[4:0] >= 5'd28)
        begin
            day_wd_off = 3'(days_reg[4:0] - 5'd28);
        end
        else if (days_reg[4:0] >= 5'd21)
        begin
            day_wd_off = 3'(days_reg[4:0] - 5'd21);
        end
        else if (days_reg[4:0] >= 5'd14)
        begin
            day_wd_off = 3'(days_reg[4:0] - 5'd14);
        end
        else if (days_reg[4:0] >= 5'd7)
        begin
            day_wd_off = 3'(days_reg[4:0] - 5'd7);
        end
        else
        begin
            day_wd_off = days_reg[2:0];
        end
    end

    // day rule
    logic [2:0] nth_n;
    logic [5:0] nth_idx;
    logic       day_ok;

    always_comb
    begin
        if (day_reg <= 5'd7)
        begin
            nth_n = 3'd0;
        end
        else if (day_reg <= 5'd14)
        begin
            nth_n = 3'd1;
        end
        else if (day_reg <= 5'd21)
        begin
            nth_n = 3'd2;
        end
        else if (day_reg <= 5'd28)
        begin
            nth_n = 3'd3;
        end
        else
        begin
            nth_n = 3'd4;
        end
        nth_idx = 6'(wd_reg) + 6'(nth_n) * 6'd7;
        day_ok  = month_mask_reg[mon_reg]
               && (dom_mask_reg[day_reg] || (dom_mask_reg[0] && (day_reg == mlen)))
               && (wday_mask_reg[wd_reg]
                   || (lwday_mask_reg[wd_reg] && (6'(day_reg) + 6'd7 > 6'(mlen)))
                   || nth_mask_reg[nth_idx]);
    end

    // scan decision
    logic               range_stop;
    logic               tod_hit;
    logic [TOD_W-1:0]   tod_sel;
    logic [START_W:0]   sum;
    logic               scan_hit;
    logic               floor_stop;
    logic [START_W-1:0] from_ext;

    assign from_ext = START_W'(from_reg);
    assign tod_hit  = first_reg ? hit_first_reg : hit_any_reg;
    assign tod_sel  = first_reg ? tod_first_reg : tod_any_reg;
    assign sum      = {1'b0, start_reg} + (START_W + 1)'(tod_sel);

    always_comb
    begin
        range_stop = 1'b0;
        if (op_reg == OP_NEXT)
        begin
            range_stop = (start_reg > TIME_MAX)
                      || (!first_reg && (start_reg - from_ext > LIMIT_SECS));
        end
        else
        begin
            range_stop = !first_reg && (from_ext - start_reg > LIMIT_SECS);
        end
    end

    assign scan_hit   = !range_stop && day_ok && tod_hit;
    assign floor_stop = (op_reg == OP_PREV) && (start_reg == '0);

    assign stat.div_done   = (cnt_reg == DIV_LAST);
    assign stat.year_more  = (days_reg >= DAY_W'(ylen));
    assign stat.month_more = (days_reg >= DAY_W'(mlen));
    assign stat.scan_end   = range_stop || scan_hit || floor_stop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_mask_reg   <= '0;
            min_mask_reg   <= '0;
            hour_mask_reg  <= '0;
            month_mask_reg <= '0;
            dom_mask_reg   <= '0;
            wday_mask_reg  <= '0;
            lwday_mask_reg <= '0;
            nth_mask_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SECOND: sec_mask_reg   <= cfg_data;
                REG_MINUTE: min_mask_reg   <= cfg_data;
                REG_HOUR:   hour_mask_reg  <= cfg_data[23:0];
                REG_MONTH:  month_mask_reg <= {cfg_data[12:1], 1'b0};
                REG_DOM:    dom_mask_reg   <= cfg_data[31:0];
                REG_WDAY:   wday_mask_reg  <= cfg_data[6:0];
                REG_LWDAY:  lwday_mask_reg <= cfg_data[6:0];
                REG_NTH:    nth_mask_reg   <= cfg_data[34:0];
                default:    sec_mask_reg   <= sec_mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            from_reg  <= from_time;
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            case (cnt_reg)
                6'd0:    n_reg    <= TIME_W'(day_prod[54:37]);
                6'd1:    tod_reg  <= tod_next;
                6'd2:    hr_reg   <= hour_prod[25:21];
                6'd3:    hrem_reg <= hrem_next;
                6'd4:    min_reg  <= min_prod[19:14];
                default: sec_reg  <= sec_next;
            endcase
        end
        if (cmd.tod_calc)
        begin
            hit_first_reg <= fh_hit;
            tod_first_reg <= ftod;
            hit_any_reg   <= ah_hit;
            tod_any_reg   <= atod;
            start_reg     <= from_ext - START_W'(tod_reg);
            days_reg      <= n_reg[DAY_W-1:0];
            y400_reg      <= EPOCH_Y400;
            mon_reg       <= 4'd1;
            day_reg       <= 5'd1;
            wd_reg        <= EPOCH_WD;
        end
        if (cmd.year_step)
        begin
            days_reg <= days_reg - DAY_W'(ylen);
            y400_reg <= y400_inc;
            wd_reg   <= wd_add(wd_reg, leap_y ? 3'd2 : 3'd1);
        end
        if (cmd.month_step)
        begin
            days_reg <= days_reg - DAY_W'(mlen);
            mon_reg  <= mon_reg + 4'd1;
            wd_reg   <= wd_add(wd_reg, 3'(mlen - 5'd28));
        end
        if (cmd.day_set)
        begin
            day_reg <= days_reg[4:0] + 5'd1;
            wd_reg  <= wd_add(wd_reg, day_wd_off);
        end
        if (cmd.scan)
        begin
            if (stat.scan_end)
            begin
                found_reg <= scan_hit && (sum <= {1'b0, TIME_MAX});
                time_reg  <= (scan_hit && (sum <= {1'b0, TIME_MAX}))
                             ? sum[TIME_W-1:0] : '0;
            end
            else if (op_reg == OP_NEXT)
            begin
                first_reg <= 1'b0;
                start_reg <= start_reg + START_W'(SECS_PER_DAY);
                wd_reg    <= wd_add(wd_reg, 3'd1);
                if (day_reg == mlen)
                begin
                    day_reg <= 5'd1;
                    if (mon_reg == 4'd12)
                    begin
                        mon_reg  <= 4'd1;
                        y400_reg <= y400_inc;
                    end
                    else
                    begin
                        mon_reg <= mon_reg + 4'd1;
                    end
                end
                else
                begin
                    day_reg <= day_reg + 5'd1;
                end
            end
            else
            begin
                first_reg <= 1'b0;
                start_reg <= start_reg - START_W'(SECS_PER_DAY);
                wd_reg    <= (wd_reg == 3'd0) ? 3'd6 : wd_reg - 3'd1;
                if (day_reg == 5'd1)
                begin
                    mon_reg  <= prev_mon;
                    y400_reg <= prev_y400;
                    day_reg  <= prev_mlen;
                end
                else
                begin
                    day_reg <= day_reg - 5'd1;
                end
            end
        end
    end

    assign found      = found_reg;
    assign match_time = time_reg;

endmodule

/* hw/rtl/schedule_mask_next_time.sv */
// schedule_mask_next_time: top level of the calendar mask search.
// Instantiates smnt_ctrl and smnt_dp; depends on smnt_pkg.
//
// Write the eight mask registers through cfg_write / cfg_index / cfg_data
// while the block is idle. All masks clear to zero at reset, so nothing
// matches until they are written.
// Input channel (in_valid/in_ready) carries op (0 next, 1 previous) and
// from_time in epoch seconds. One item is worked on at a time; in_ready
// is high only while the block is idle.
// Output channel (out_valid/out_ready) carries found and match_time. The
// result holds until out_ready is seen; a stalled receiver holds the block.
// The sequencer walks the calendar: it accepts the item, splits from_time
// into day and h:m:s, works out the time-of-day candidates, steps through
// the years since 1970 one at a time and then the months, and scans one day
// at a time (up to about 1828 days for the five year window) before the
// result is offered. The next item is taken the cycle after the result is
// accepted.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// any item in flight.
module schedule_mask_next_time (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [2:0]                    cfg_index,
    input  logic [smnt_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [smnt_pkg::TIME_W-1:0]   from_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [smnt_pkg::TIME_W-1:0]   match_time
);
    import smnt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    smnt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    smnt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .from_time  (from_time),
        .cmd        (cmd),
        .stat       (stat),
        .found      (found),
        .match_time (match_time)
    );

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second item while busy");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_time == '0))
        else $error("match_time not zero without a match");

endmodule

/* sim/schedule_mask_next_time_tb.sv */
// Testbench for schedule_mask_next_time: drives next/previous calendar searches
// under several mask settings and idle patterns, and checks each result against
// an in-bench predictor. Depends on smnt_pkg and the block's RTL.
`timescale 1ns / 100ps

module schedule_mask_next_time_tb;
    import smnt_pkg::*;

    localparam longint unsigned DAY_SECS  = 86400;
    localparam longint unsigned MAX_TIME  = 64'h3FFFFFFFF;
    localparam longint unsigned WINDOW    = 5 * 31556952;

    class next_time_board;
        logic [63:0]      masks[8];
        bit               want_found[$];
        longint unsigned  want_time[$];
        int               errors;

        function new();
            for (int i = 0; i < 8; i++)
            begin
                masks[i] = '0;
            end
            errors = 0;
        endfunction

        function bit has(logic [2:0] idx, int pos);
            return pos >= 0 && pos < 64 && masks[idx][pos] === 1'b1;
        endfunction

        function int tod_at_or_after(int lo);
            int t;
            for (int h = 0; h < 24; h++)
            begin
                if (!has(REG_HOUR, h) || h * 3600 + 3599 < lo) continue;
                for (int m = 0; m < 60; m++)
                begin
                    if (!has(REG_MINUTE, m) || h * 3600 + m * 60 + 59 < lo) continue;
                    for (int s = 0; s < 60; s++)
                    begin
                        t = h * 3600 + m * 60 + s;
                        if (t >= lo && has(REG_SECOND, s)) return t;
                    end
                end
            end
            return -1;
        endfunction

        function int tod_at_or_before(int hi);
            int t;
            for (int h = 23; h >= 0; h--)
            begin
                if (!has(REG_HOUR, h) || h * 3600 > hi) continue;
                for (int m = 59; m >= 0; m--)
                begin
                    if (!has(REG_MINUTE, m) || h * 3600 + m * 60 > hi) continue;
                    for (int s = 59; s >= 0; s--)
                    begin
                        t = h * 3600 + m * 60 + s;
                        if (t <= hi && has(REG_SECOND, s)) return t;
                    end
                end
            end
            return -1;
        endfunction

        function bit day_matches(longint unsigned dn);
            longint unsigned z, era, doe, yoe, y, doy, mp;
            int d, mon, last, wd;
            z = dn + 719468;
            era = z / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            y = yoe + era * 400;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp = (5 * doy + 2) / 153;
            d = int'(doy - (153 * mp + 2) / 5 + 1);
            mon = (mp < 10) ? int'(mp + 3) : int'(mp - 9);
            if (mon <= 2) y++;
            case (mon)
                2: last = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
                4, 6, 9, 11: last = 30;
                default: last = 31;
            endcase
            wd = int'((dn + 4) % 7);
            if (!has(REG_MONTH, mon)) return 0;
            if (!(has(REG_DOM, d) || (has(REG_DOM, 0) && d == last))) return 0;
            return has(REG_WDAY, wd) || (has(REG_LWDAY, wd) && d + 7 > last)
                || has(REG_NTH, wd + 7 * ((d - 1) / 7));
        endfunction

        function void note_query(logic op, logic [TIME_W-1:0] from);
            longint unsigned d0, dn, start, fr, res;
            int ftod, t;
            bit ok;
            fr = from;
            d0 = fr / DAY_SECS;
            ftod = int'(fr % DAY_SECS);
            dn = d0;
            ok = 0;
            res = 0;
            forever
            begin
                start = dn * DAY_SECS;
                if (op == OP_NEXT)
                begin
                    if (start > MAX_TIME) break;
                    if (dn != d0 && start - fr > WINDOW) break;
                end
                else if (dn != d0 && fr - start > WINDOW) break;
                if (day_matches(dn))
                begin
                    if (op == OP_NEXT)
                        t = (dn == d0) ? (ftod + 1 < DAY_SECS ? tod_at_or_after(ftod + 1) : -1)
                                       : tod_at_or_after(0);
                    else
                        t = (dn == d0) ? (ftod > 0 ? tod_at_or_before(ftod - 1) : -1)
                                       : tod_at_or_before(int'(DAY_SECS) - 1);
                    if (t >= 0)
                    begin
                        res = start + 64'(t);
                        ok = res <= MAX_TIME;
                        if (!ok) res = 0;
                        break;
                    end
                end
                if (op == OP_NEXT) dn++;
                else
                begin
                    if (dn == 0) break;
                    dn--;
                end
            end
            want_found.push_back(ok);
            want_time.push_back(ok ? res : 0);
        endfunction

        task flag(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_answer(logic f, logic [TIME_W-1:0] mt);
            bit ef;
            longint unsigned et;
            if (want_found.size() == 0)
            begin
                flag("result with no query outstanding");
                return;
            end
            ef = want_found.pop_front();
            et = want_time.pop_front();
            if (f !== ef)
                flag($sformatf("found %b, expected %b", f, ef));
            if (mt !== TIME_W'(et))
                flag($sformatf("match_time %0d, expected %0d", mt, et));
        endtask

        function int outstanding();
            return want_found.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [2:0]          cfg_index = REG_SECOND;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                op = OP_NEXT;
    logic [TIME_W-1:0]   from_time = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                found;
    logic [TIME_W-1:0]   match_time;

    next_time_board board = new();
    int sender_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;

    schedule_mask_next_time dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .from_time(from_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .match_time(match_time)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: long hold-off when asked, else random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_answer(found, match_time);
    end

    task drain();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task set_masks(logic [63:0] s, logic [63:0] m, logic [63:0] h, logic [63:0] mo,
                   logic [63:0] d, logic [63:0] w, logic [63:0] lw, logic [63:0] n);
        logic [63:0] v[8];
        v[0] = s & 64'hFFFFFFFFFFFFFFF;
        v[1] = m & 64'hFFFFFFFFFFFFFFF;
        v[2] = h & 64'hFFFFFF;
        v[3] = mo & 64'h1FFE;
        v[4] = d & 64'hFFFFFFFF;
        v[5] = w & 64'h7F;
        v[6] = lw & 64'h7F;
        v[7] = n & 64'h7FFFFFFFF;
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= v[i][CFG_W-1:0];
            board.masks[i] = v[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task send(logic o, logic [TIME_W-1:0] t);
        while (sender_idle > 0 && $urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        from_time <= t;
        forever
        begin
            @(negedge clk);
            if (in_ready) break;
        end
        @(posedge clk);
        board.note_query(o, t);
    endtask

    function logic [63:0] pick_mask(int width);
        logic [63:0] r;
        case ($urandom_range(3))
            0: r = '1;
            1: r = {$urandom, $urandom};
            2: r = 64'(1) << $urandom_range(width - 1);
            default: r = (64'(1) << $urandom_range(width - 1))
                       | (64'(1) << $urandom_range(width - 1));
        endcase
        return r;
    endfunction

    function logic [TIME_W-1:0] pick_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return TIME_W'(r);
            1: return TIME_W'($urandom_range(200000));
            2: return TIME_W'(MAX_TIME - $urandom_range(200000));
            default: return TIME_W'(r % 64'd4102444800);
        endcase
    endfunction

    initial
    begin
        logic [63:0] wd;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        @(posedge clk);

        // every second matches
        set_masks('1, '1, '1, '1, '1, '1, '1, '1);
        send(OP_NEXT, '0);
        send(OP_PREV, '0);
        send(OP_NEXT, '1);
        send(OP_PREV, '1);
        send(OP_NEXT, TIME_W'(86399));
        send(OP_PREV, TIME_W'(86400));
        drain();
        // nothing matches: full window scan
        set_masks('0, '0, '0, '0, '0, '0, '0, '0);
        send(OP_NEXT, TIME_W'(1000000000));
        send(OP_PREV, TIME_W'(1000000000));
        drain();
        // leap day at noon
        set_masks(64'h1, 64'h1, 64'h1000, 64'h4, 64'(1) << 29, '1, '0, '0);
        send(OP_NEXT, '0);
        send(OP_PREV, TIME_W'(1700000000));
        drain();
        // last day of month, last Friday, second Tuesday
        set_masks(64'h1, 64'h1, 64'h1, '1, 64'h1, '1, '0, '0);
        send(OP_NEXT, TIME_W'(1600000000));
        send(OP_PREV, TIME_W'(1600000000));
        drain();
        set_masks(64'h1, 64'h1, 64'h1, '1, '1, '0, 64'h20, '0);
        send(OP_NEXT, TIME_W'(1600000000));
        send(OP_PREV, TIME_W'(1600000000));
        drain();
        set_masks(64'h1, 64'h1, 64'h1, '1, '1, '0, '0, 64'h4 << 7);
        send(OP_NEXT, TIME_W'(1600000000));
        send(OP_PREV, TIME_W'(1600000000));
        drain();
        // day 31 in April never exists; match only at top of range
        set_masks('1, '1, '1, 64'h10, 64'(1) << 31, '1, '0, '0);
        send(OP_NEXT, TIME_W'(1600000000));
        drain();
        set_masks(64'(1) << 59, 64'(1) << 59, 64'h800000, '1, '1, '1, '0, '0);
        send(OP_NEXT, TIME_W'(MAX_TIME - 10));
        send(OP_PREV, TIME_W'(100));
        send(OP_PREV, TIME_W'(86400 + 5));
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 83; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 83; end
                default: begin sender_idle = 16; recv_stall = 16; end
            endcase
            wd = ($urandom_range(2) == 0) ? pick_mask(7) : '1;
            set_masks(pick_mask(60), pick_mask(60), pick_mask(24),
                      ($urandom_range(1) == 1) ? 64'h1FFE : pick_mask(13) << 1,
                      ($urandom_range(1) == 1) ? 64'hFFFFFFFF : pick_mask(32),
                      wd, pick_mask(7), pick_mask(35));
            if (ph == 5) hold_left = 5000;
            for (int k = 0; k < 22; k++)
                send(1'($urandom_range(1)), pick_time());
            drain();
        end
        drain();
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
